### hdl/mcled_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcled_pkg: shared types and constants of the LED PWM dimmer
// Item layouts of the command and result channels, command and status codes,
// configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package mcled_pkg;

	localparam int OUT_W   = 6;
	localparam int LEVEL_W = 7;
	localparam int COUNT_W = 8;
	localparam int CFG_W   = 8;

	typedef struct packed {
		logic [2:0]  mode;
		logic [7:0]  led_select;
		logic [15:0] value;
		logic [3:0]  length;
	} cmd_item_t;

	typedef struct packed {
		logic [OUT_W-1:0]   led_outputs;
		logic [2:0]         status;
		logic               selected_on;
		logic [LEVEL_W-1:0] selected_level;
	} rsp_item_t;

	// Command codes; every code above MODE_SET_LEVEL is unknown.
	localparam logic [2:0] MODE_TICK      = 3'd0;
	localparam logic [2:0] MODE_TOGGLE    = 3'd1;
	localparam logic [2:0] MODE_SET_STATE = 3'd2;
	localparam logic [2:0] MODE_SET_LEVEL = 3'd3;

	localparam logic [2:0] STATUS_OK        = 3'd0;
	localparam logic [2:0] STATUS_SHORT     = 3'd1;
	localparam logic [2:0] STATUS_UNKNOWN   = 3'd2;
	localparam logic [2:0] STATUS_BAD_LED   = 3'd3;
	localparam logic [2:0] STATUS_AUTO_LVL  = 3'd4;

	localparam logic [3:0] LEN_MIN       = 4'd2;
	localparam logic [3:0] LEN_SET_STATE = 4'd3;
	localparam logic [3:0] LEN_SET_LEVEL = 4'd4;

	localparam logic CFG_PERIOD_LENGTH = 1'b0;
	localparam logic CFG_DEFAULT_LEVEL = 1'b1;

	localparam logic [COUNT_W-1:0] PERIOD_RESET = 8'd100;
	localparam logic [LEVEL_W-1:0] LEVEL_RESET  = 7'd50;
	localparam logic [LEVEL_W-1:0] MAX_LEVEL    = 7'd100;

	// Per-mille values at or above this give a level of at least 101.
	localparam logic [15:0] PERMILLE_SAT = 16'd1010;
	// Reciprocal of ten in 11 fractional bits; exact for inputs below 1029.
	localparam logic [7:0]  RECIP_TEN    = 8'd205;

	// Per-mille to level: value / 10 saturated at MAX_LEVEL.
	function automatic logic [LEVEL_W-1:0] permille_to_level(input logic [15:0] permille);
		logic [17:0] prod;
		begin
			prod = {8'd0, permille[9:0]} * {10'd0, RECIP_TEN};
			if (permille >= PERMILLE_SAT) begin
				permille_to_level = MAX_LEVEL;
			end else begin
				permille_to_level = prod[17:11];
			end
		end
	endfunction

endpackage
`default_nettype wire

### hdl/mcled_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcled_engine: LED state and per-item update
// Holds the period counter, on flags and levels, applies one command or tick
// when an item is taken and forms its result from the updated state.
// ----------------------------------------------------------------------------
module mcled_engine #(
	parameter int NUM_LEDS = 6
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                fire,
	input  mcled_pkg::cmd_item_t               cmd,
	input  wire [mcled_pkg::COUNT_W-1:0]       period_length,
	input  wire [mcled_pkg::LEVEL_W-1:0]       default_level,
	output mcled_pkg::rsp_item_t               rsp
);

	logic [mcled_pkg::COUNT_W-1:0] tick_q, tick_d, tick_inc;
	logic [NUM_LEDS-1:0]           on_q, on_d;
	logic [mcled_pkg::LEVEL_W-1:0] level_q [NUM_LEDS];
	logic [mcled_pkg::LEVEL_W-1:0] level_d [NUM_LEDS];
	logic [NUM_LEDS-1:0]           hit, auto_lvl;
	logic [mcled_pkg::LEVEL_W-1:0] new_level;
	logic                          is_tick, too_short, unknown, sel_ok, cmd_ok;
	logic                          sel_on;
	logic [mcled_pkg::LEVEL_W-1:0] sel_level;
	logic [2:0]                    status;

	assign is_tick   = (cmd.mode == mcled_pkg::MODE_TICK);
	assign unknown   = (cmd.mode > mcled_pkg::MODE_SET_LEVEL);
	assign too_short = (cmd.length < mcled_pkg::LEN_MIN)
		|| (cmd.mode == mcled_pkg::MODE_SET_STATE && cmd.length < mcled_pkg::LEN_SET_STATE)
		|| (cmd.mode == mcled_pkg::MODE_SET_LEVEL && cmd.length < mcled_pkg::LEN_SET_LEVEL);
	assign sel_ok    = (cmd.led_select != 8'd0) && (cmd.led_select <= 8'(NUM_LEDS));
	assign cmd_ok    = !is_tick && !too_short && !unknown && sel_ok;
	assign new_level = mcled_pkg::permille_to_level(cmd.value);

	// The counter wraps at 256 before the period compare.
	always_comb begin
		tick_inc = tick_q + 8'd1;
		tick_d   = tick_q;
		if (is_tick) begin
			tick_d = (tick_inc >= period_length) ? '0 : tick_inc;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_LEDS; i++) begin
			hit[i]      = cmd_ok && (cmd.led_select == 8'(i + 1));
			on_d[i]     = on_q[i];
			level_d[i]  = level_q[i];
			auto_lvl[i] = 1'b0;
			if (hit[i]) begin
				unique case (cmd.mode)
					mcled_pkg::MODE_TOGGLE: begin
						on_d[i] = !on_q[i];
						if (!on_q[i] && level_q[i] == '0) begin
							level_d[i]  = default_level;
							auto_lvl[i] = 1'b1;
						end
					end
					mcled_pkg::MODE_SET_STATE: on_d[i] = (cmd.value != 16'd0);
					mcled_pkg::MODE_SET_LEVEL: level_d[i] = new_level;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		sel_on    = 1'b0;
		sel_level = '0;
		for (int i = 0; i < NUM_LEDS; i++) begin
			sel_on    = sel_on | (hit[i] & on_d[i]);
			sel_level = sel_level | (hit[i] ? level_d[i] : '0);
		end
	end

	always_comb begin
		priority if (is_tick) begin
			status = mcled_pkg::STATUS_OK;
		end else if (too_short) begin
			status = mcled_pkg::STATUS_SHORT;
		end else if (unknown) begin
			status = mcled_pkg::STATUS_UNKNOWN;
		end else if (!sel_ok) begin
			status = mcled_pkg::STATUS_BAD_LED;
		end else if (|auto_lvl) begin
			status = mcled_pkg::STATUS_AUTO_LVL;
		end else begin
			status = mcled_pkg::STATUS_OK;
		end
	end

	// Drive bits come from the state as it stands after this item.
	for (genvar g = 0; g < mcled_pkg::OUT_W; g++) begin : g_drive
		if (g < NUM_LEDS) begin : g_led
			assign rsp.led_outputs[g] = on_d[g] && (tick_d < {1'b0, level_d[g]});
		end else begin : g_none
			assign rsp.led_outputs[g] = 1'b0;
		end
	end

	assign rsp.status         = status;
	assign rsp.selected_on    = sel_on;
	assign rsp.selected_level = sel_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			on_q   <= '0;
			for (int i = 0; i < NUM_LEDS; i++) begin
				level_q[i] <= mcled_pkg::LEVEL_RESET;
			end
		end else if (fire) begin
			tick_q <= tick_d;
			on_q   <= on_d;
			for (int i = 0; i < NUM_LEDS; i++) begin
				level_q[i] <= level_d[i];
			end
		end
	end

endmodule
`default_nettype wire

### hdl/multi_channel_led_pwm_controller.sv
// Path: accepted item -> input register -> state update -> result register.
// Throughput: one item per cycle; the input register feeds the state update and
// result register in one pass, so only a stalled result slows intake.
// Reset (arst_n low): counter 0, all LEDs off, levels 50, period 100,
// default level 50, both channels empty.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_led_pwm_controller: six-channel PWM LED dimmer
// Tick items advance the PWM period counter; command items toggle, switch or
// dim one LED. Every item yields one result with drive bits and status.
// ----------------------------------------------------------------------------
module multi_channel_led_pwm_controller #(
	parameter int NUM_LEDS = 6
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cmd_valid,
	output logic                           cmd_ready,
	input  mcled_pkg::cmd_item_t           cmd,
	output logic                           rsp_valid,
	input  wire                            rsp_ready,
	output mcled_pkg::rsp_item_t           rsp,
	input  wire                            cfg_we,
	input  wire                            cfg_index,
	input  wire [mcled_pkg::CFG_W-1:0]     cfg_data
);

	logic                          valid_s1;
	mcled_pkg::cmd_item_t          cmd_s1;
	logic                          advance;
	logic                          fire;
	mcled_pkg::rsp_item_t          rsp_comb;
	logic [mcled_pkg::COUNT_W-1:0] period_q;
	logic [mcled_pkg::LEVEL_W-1:0] dflt_level_q;

	// The input stage moves on whenever the result register is free or being taken.
	assign advance   = !rsp_valid || rsp_ready;
	assign fire      = valid_s1 && advance;
	assign cmd_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (advance) begin
			rsp_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp <= rsp_comb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= mcled_pkg::PERIOD_RESET;
			dflt_level_q <= mcled_pkg::LEVEL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mcled_pkg::CFG_PERIOD_LENGTH: period_q <= cfg_data;
				mcled_pkg::CFG_DEFAULT_LEVEL: begin
					dflt_level_q <= (cfg_data[6:0] > mcled_pkg::MAX_LEVEL)
						? mcled_pkg::MAX_LEVEL : cfg_data[6:0];
				end
				default: ;
			endcase
		end
	end

	mcled_engine #(
		.NUM_LEDS(NUM_LEDS)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.cmd           (cmd_s1),
		.period_length (period_q),
		.default_level (dflt_level_q),
		.rsp           (rsp_comb)
	);

endmodule
`default_nettype wire
